[hw/rtl/adq_pkg.sv]
// Shared types and codes for the array deque with sort and reverse.
package adq_pkg;

	localparam int FUNC_W   = 4;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 8;
	localparam int STATUS_W = 2;

	// Request codes
	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_POP_FRONT  = 4'd2,
		OP_POP_BACK   = 4'd3,
		OP_PEEK_FRONT = 4'd4,
		OP_PEEK_BACK  = 4'd5,
		OP_SIZE       = 4'd6,
		OP_REVERSE    = 4'd7,
		OP_SORT       = 4'd8
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STS_OK       = 2'd0,
		STS_OVERFLOW = 2'd1,
		STS_NO_FRONT = 2'd2,
		STS_EMPTY    = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_POP,
		S_REV_RI,
		S_REV_RJ,
		S_REV_WI,
		S_REV_WJ,
		S_SRT_LD,
		S_SRT_CMP,
		S_SRT_WI,
		S_FIN
	} state_t;

endpackage

[hw/rtl/adq_req_if.sv]
// Request channel: valid/ready handshake with request code and push data.
interface adq_req_if;
	logic                                valid;
	logic                                ready;
	logic [adq_pkg::FUNC_W-1:0]          func;
	logic signed [adq_pkg::VALUE_W-1:0]  data_in;

	modport source (output valid, output func, output data_in, input ready);
	modport sink   (input valid, input func, input data_in, output ready);
endinterface

[hw/rtl/adq_rsp_if.sv]
// Response channel: valid/ready handshake with value, count and status.
interface adq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [adq_pkg::VALUE_W-1:0]  value_out;
	logic [adq_pkg::COUNT_W-1:0]         count_out;
	logic [adq_pkg::STATUS_W-1:0]        status;

	modport source (output valid, output value_out, output count_out, output status, input ready);
	modport sink   (input valid, input value_out, input count_out, input status, output ready);
endinterface

[hw/rtl/adq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module adq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/adq_cmp.sv]
// Shared signed (two's complement) compare used by the sort walk.
module adq_cmp #(
	parameter int WIDTH = 32
) (
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	output logic             gt
);

	// a > b, both taken as two's complement
	assign gt = $signed(a) > $signed(b);

endmodule

[hw/rtl/array_deque_with_sort_reverse.sv]
// Push, size, unknown codes go IDLE then FIN; a non-empty pop/peek goes IDLE, POP, FIN.
// Reverse: per swapped pair, read i, read j, write i, write j (one RAM read port, one write port).
// Sort: each slot is loaded, compared with every later slot and written back, one compare a cycle.
// One request in flight; the next is taken the cycle after its result enters the output register.
// Reset (arst_n low, asynchronous): deque empty, both indices 0, no result pending.
// Store contents are not cleared; only slots between the indices are ever read.
module array_deque_with_sort_reverse #(
	parameter int DEPTH      = 128,
	parameter int DATA_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	adq_req_if.sink    req,
	adq_rsp_if.source  rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

	adq_pkg::state_t state_q, state_d;

	logic [IW-1:0] front_q, rear_q, i_q, j_q;
	logic          empty_q;

	logic [DATA_WIDTH-1:0]        cur_q;
	logic [adq_pkg::FUNC_W-1:0]   func_q;
	logic [adq_pkg::VALUE_W-1:0]  res_value_q;
	logic [adq_pkg::STATUS_W-1:0] res_status_q;

	logic                          out_valid_q;
	logic [adq_pkg::VALUE_W-1:0]   out_value_q;
	logic [adq_pkg::COUNT_W-1:0]   out_count_q;
	logic [adq_pkg::STATUS_W-1:0]  out_status_q;

	logic                  mem_we;
	logic [IW-1:0]         mem_waddr, mem_raddr;
	logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

	logic                  accept, full, cur_gt, fin_go, rev_more;
	logic [63:0]           din_ext, rd_ext;
	logic [DATA_WIDTH-1:0] push_data;
	logic [CW-1:0]         cnt;

	// element store
	adq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// compare unit shared by every step of the sort
	adq_cmp #(
		.WIDTH (DATA_WIDTH)
	) u_cmp (
		.a  (cur_q),
		.b  (mem_rdata),
		.gt (cur_gt)
	);

	// handshake and derived status
	assign req.ready = (state_q == adq_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = !empty_q && (rear_q == LAST);
	assign fin_go    = !out_valid_q || rsp.ready;
	assign rev_more  = (i_q + IW'(1)) < (j_q - IW'(1));
	assign cnt       = empty_q ? '0 : CW'(rear_q - front_q) + CW'(1);

	// data width conversion: sign extend on store, zero extend on read
	assign din_ext   = 64'(req.data_in);
	assign push_data = din_ext[DATA_WIDTH-1:0];
	assign rd_ext    = 64'(mem_rdata);

	assign rsp.valid     = out_valid_q;
	assign rsp.value_out = out_value_q;
	assign rsp.count_out = out_count_q;
	assign rsp.status    = out_status_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			adq_pkg::S_IDLE: begin
				if (accept) begin
					if (req.func == adq_pkg::OP_REVERSE) begin
						state_d = (empty_q || front_q == rear_q) ? adq_pkg::S_FIN
							: adq_pkg::S_REV_RI;
					end else if (req.func == adq_pkg::OP_SORT) begin
						state_d = (empty_q || front_q == rear_q) ? adq_pkg::S_FIN
							: adq_pkg::S_SRT_LD;
					end else if (req.func inside {adq_pkg::OP_POP_FRONT, adq_pkg::OP_POP_BACK,
							adq_pkg::OP_PEEK_FRONT, adq_pkg::OP_PEEK_BACK}) begin
						state_d = empty_q ? adq_pkg::S_FIN : adq_pkg::S_POP;
					end else begin
						state_d = adq_pkg::S_FIN;
					end
				end
			end
			adq_pkg::S_POP:     state_d = adq_pkg::S_FIN;
			adq_pkg::S_REV_RI:  state_d = adq_pkg::S_REV_RJ;
			adq_pkg::S_REV_RJ:  state_d = adq_pkg::S_REV_WI;
			adq_pkg::S_REV_WI:  state_d = adq_pkg::S_REV_WJ;
			adq_pkg::S_REV_WJ:  state_d = rev_more ? adq_pkg::S_REV_RI : adq_pkg::S_FIN;
			adq_pkg::S_SRT_LD:  state_d = adq_pkg::S_SRT_CMP;
			adq_pkg::S_SRT_CMP: state_d = (j_q == rear_q) ? adq_pkg::S_SRT_WI
				: adq_pkg::S_SRT_CMP;
			adq_pkg::S_SRT_WI:  state_d = (i_q + IW'(1) == rear_q) ? adq_pkg::S_FIN
				: adq_pkg::S_SRT_LD;
			adq_pkg::S_FIN:     state_d = fin_go ? adq_pkg::S_IDLE : adq_pkg::S_FIN;
			default:            state_d = adq_pkg::S_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_q;
		mem_wdata = cur_q;
		mem_raddr = i_q;
		case (state_q)
			adq_pkg::S_IDLE: begin
				mem_wdata = push_data;
				if (req.func inside {adq_pkg::OP_POP_FRONT, adq_pkg::OP_PEEK_FRONT,
						adq_pkg::OP_SORT}) begin
					mem_raddr = front_q;
				end else begin
					mem_raddr = rear_q;
				end
				if (accept && !full) begin
					case (req.func)
						adq_pkg::OP_PUSH_FRONT: begin
							if (empty_q) begin
								mem_we    = 1'b1;
								mem_waddr = '0;
							end else if (front_q != '0) begin
								mem_we    = 1'b1;
								mem_waddr = front_q - IW'(1);
							end
						end
						adq_pkg::OP_PUSH_BACK: begin
							mem_we    = 1'b1;
							mem_waddr = empty_q ? '0 : rear_q + IW'(1);
						end
						default: mem_we = 1'b0;
					endcase
				end
			end
			adq_pkg::S_REV_RI: mem_raddr = i_q;
			adq_pkg::S_REV_RJ: mem_raddr = j_q;
			adq_pkg::S_REV_WI: begin
				mem_we    = 1'b1;
				mem_waddr = i_q;
				mem_wdata = mem_rdata;
			end
			adq_pkg::S_REV_WJ: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
			end
			adq_pkg::S_SRT_LD: mem_raddr = j_q;
			adq_pkg::S_SRT_CMP: begin
				// read ahead one slot while the compare runs on the current one
				mem_raddr = (j_q == rear_q) ? j_q : j_q + IW'(1);
				mem_we    = cur_gt;
				mem_waddr = j_q;
			end
			adq_pkg::S_SRT_WI: begin
				mem_we    = 1'b1;
				mem_waddr = i_q;
				mem_raddr = i_q + IW'(1);
			end
			default: mem_we = 1'b0;
		endcase
	end

	// state and indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= adq_pkg::S_IDLE;
			front_q     <= '0;
			rear_q      <= '0;
			empty_q     <= 1'b1;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				adq_pkg::S_IDLE: begin
					if (accept) begin
						case (req.func)
							adq_pkg::OP_PUSH_FRONT: begin
								if (!full) begin
									if (empty_q) begin
										empty_q <= 1'b0;
										front_q <= '0;
										rear_q  <= '0;
									end else if (front_q != '0) begin
										front_q <= front_q - IW'(1);
									end
								end
							end
							adq_pkg::OP_PUSH_BACK: begin
								if (!full) begin
									if (empty_q) begin
										empty_q <= 1'b0;
										front_q <= '0;
										rear_q  <= '0;
									end else begin
										rear_q <= rear_q + IW'(1);
									end
								end
							end
							adq_pkg::OP_REVERSE: begin
								i_q <= front_q;
								j_q <= rear_q;
							end
							adq_pkg::OP_SORT: begin
								i_q <= front_q;
								j_q <= front_q + IW'(1);
							end
							default: i_q <= i_q;
						endcase
					end
				end
				adq_pkg::S_POP: begin
					if (func_q == adq_pkg::OP_POP_FRONT || func_q == adq_pkg::OP_POP_BACK) begin
						if (front_q == rear_q) begin
							empty_q <= 1'b1;
							front_q <= '0;
							rear_q  <= '0;
						end else if (func_q == adq_pkg::OP_POP_FRONT) begin
							front_q <= front_q + IW'(1);
						end else begin
							rear_q <= rear_q - IW'(1);
						end
					end
				end
				adq_pkg::S_REV_WJ: begin
					i_q <= i_q + IW'(1);
					j_q <= j_q - IW'(1);
				end
				adq_pkg::S_SRT_CMP: begin
					if (j_q != rear_q) begin
						j_q <= j_q + IW'(1);
					end
				end
				adq_pkg::S_SRT_WI: begin
					i_q <= i_q + IW'(1);
					j_q <= i_q + IW'(2);
				end
				default: i_q <= i_q;
			endcase
			// output register: filled from FIN, drained by a transfer
			if (state_q == adq_pkg::S_FIN && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			adq_pkg::S_IDLE: begin
				if (accept) begin
					func_q       <= req.func;
					res_value_q  <= '0;
					res_status_q <= adq_pkg::STS_OK;
					case (req.func)
						adq_pkg::OP_PUSH_FRONT: begin
							if (full) begin
								res_status_q <= adq_pkg::STS_OVERFLOW;
							end else if (!empty_q && front_q == '0) begin
								res_status_q <= adq_pkg::STS_NO_FRONT;
							end
						end
						adq_pkg::OP_PUSH_BACK: begin
							if (full) begin
								res_status_q <= adq_pkg::STS_OVERFLOW;
							end
						end
						adq_pkg::OP_POP_FRONT, adq_pkg::OP_POP_BACK,
						adq_pkg::OP_PEEK_FRONT, adq_pkg::OP_PEEK_BACK: begin
							if (empty_q) begin
								res_value_q  <= '1;
								res_status_q <= adq_pkg::STS_EMPTY;
							end
						end
						default: res_status_q <= adq_pkg::STS_OK;
					endcase
				end
			end
			adq_pkg::S_POP:    res_value_q <= rd_ext[adq_pkg::VALUE_W-1:0];
			adq_pkg::S_REV_RJ: cur_q <= mem_rdata;
			adq_pkg::S_SRT_LD: cur_q <= mem_rdata;
			adq_pkg::S_SRT_CMP: begin
				// keep the smaller one; the larger went back to slot j
				if (cur_gt) begin
					cur_q <= mem_rdata;
				end
			end
			adq_pkg::S_FIN: begin
				if (fin_go) begin
					out_value_q  <= res_value_q;
					out_count_q  <= adq_pkg::COUNT_W'(cnt);
					out_status_q <= res_status_q;
				end
			end
			default: cur_q <= cur_q;
		endcase
	end

`ifndef ASSERT_OFF
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> rear_q >= front_q)
		else $error("rear index below front index");

	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (front_q == '0 && rear_q == '0))
		else $error("empty deque with nonzero index");

	a_sort_j: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == adq_pkg::S_SRT_CMP |-> (j_q > i_q && j_q <= rear_q))
		else $error("sort inner index out of range");

	a_rev_ij: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == adq_pkg::S_REV_RI || state_q == adq_pkg::S_REV_RJ ||
		 state_q == adq_pkg::S_REV_WI || state_q == adq_pkg::S_REV_WJ) |-> i_q < j_q)
		else $error("reverse indices crossed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != adq_pkg::S_IDLE)
		else $error("request transfer did not start a sequence");
`endif

endmodule
